FILE: src/ps2kc_pkg.sv
package ps2kc_pkg;

  // Sizes.
  localparam int QUEUE_DEPTH = 256;
  localparam int RAM_BYTES   = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_AW      = $clog2(RAM_BYTES);
  localparam int MAX_OPS     = 4;
  localparam int OP_IDX_W    = $clog2(MAX_OPS);
  localparam int OP_CNT_W    = $clog2(MAX_OPS + 1);

  // Item modes.
  localparam logic [2:0] MODE_READ   = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_KEY    = 3'd2;
  localparam logic [2:0] MODE_MOVE   = 3'd3;
  localparam logic [2:0] MODE_BUTTON = 3'd4;

  // Status byte bits.
  localparam logic [7:0] STAT_OFULL   = 8'h01;
  localparam logic [7:0] STAT_SYS     = 8'h04;
  localparam logic [7:0] STAT_CMD     = 8'h08;
  localparam logic [7:0] STAT_AUX     = 8'h20;
  localparam logic [7:0] STAT_TIMEOUT = 8'h40;
  localparam logic [7:0] STAT_RESET   = 8'h18;

  // Command byte bits and defaults.
  localparam logic [7:0] CB_AUX_OFF  = 8'h20;
  localparam logic [7:0] CB_KBD_OFF  = 8'h10;
  localparam logic [7:0] CB_DEFAULT  = 8'h05;
  localparam logic [7:0] MOUSE_RES_DEFAULT  = 8'd4;
  localparam logic [7:0] MOUSE_RATE_DEFAULT = 8'd100;

  // Reply bytes.
  localparam logic [7:0] BYTE_ACK      = 8'hFA;
  localparam logic [7:0] BYTE_RESEND   = 8'hFE;
  localparam logic [7:0] BYTE_BAT_OK   = 8'hAA;
  localparam logic [7:0] BYTE_SELFTEST = 8'h55;
  localparam logic [7:0] BYTE_ID_LOW   = 8'h41;
  localparam logic [7:0] BYTE_INPORT   = 8'h40;
  localparam logic [7:0] PKT_BASE      = 8'h08;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_ACT,
    S_SETTLE,
    S_FIN,
    S_DONE
  } ctrl_state_e;

  // Queue operation kinds.
  typedef enum logic {
    OP_PUSH,
    OP_REFILL
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic       q;
    logic       raise;
    logic [7:0] value;
  } op_t;

  typedef struct packed {
    logic                decode;
    logic                act;
    logic                fin;
    logic [OP_IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_CNT_W-1:0] n_ops;
  } dp_status_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic               port_select;
    logic [7:0]         data;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic               left_set;
    logic               left_down;
    logic               middle_set;
    logic               middle_down;
    logic               right_set;
    logic               right_down;
  } item_t;

  function automatic op_t mk_push(logic q, logic [7:0] value);
    op_t o;
    o.kind  = OP_PUSH;
    o.q     = q;
    o.raise = 1'b0;
    o.value = value;
    return o;
  endfunction

  function automatic op_t mk_refill(logic raise, logic q);
    op_t o;
    o.kind  = OP_REFILL;
    o.q     = q;
    o.raise = raise;
    o.value = 8'h00;
    return o;
  endfunction

endpackage

FILE: src/ps2kc_ram.sv
module ps2kc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/ps2kc_ctrl.sv
module ps2kc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  output logic                  done_o,
  output ps2kc_pkg::dp_cmd_t    cmd_o,
  input  ps2kc_pkg::dp_status_t status_i
);

  import ps2kc_pkg::*;

  ctrl_state_e         state_q, state_d;
  logic [OP_CNT_W-1:0] idx_q, idx_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start_i) state_d = S_NEXT;
      S_NEXT:   state_d = (idx_q == status_i.n_ops) ? S_DONE : S_ACT;
      S_ACT:    state_d = S_SETTLE;
      S_SETTLE: state_d = S_FIN;
      S_FIN:    state_d = S_NEXT;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Operation index: cleared on accept, advanced after each operation.
  always_comb begin
    idx_d = idx_q;
    if (state_q == S_IDLE) begin
      idx_d = '0;
    end else if (state_q == S_FIN) begin
      idx_d = idx_q + OP_CNT_W'(1);
    end
  end

  // Outputs.
  always_comb begin
    cmd_o.decode = (state_q == S_IDLE) && start_i;
    cmd_o.act    = (state_q == S_ACT);
    cmd_o.fin    = (state_q == S_FIN);
    cmd_o.idx    = idx_q[OP_IDX_W-1:0];
    busy_o       = (state_q != S_IDLE);
    done_o       = (state_q == S_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

FILE: src/ps2kc_datapath.sv
module ps2kc_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ps2kc_pkg::dp_cmd_t    cmd_i,
  output ps2kc_pkg::dp_status_t status_o,
  input  ps2kc_pkg::item_t      item_i,
  output logic [7:0]            read_data_o,
  output logic [1:0]            irq_line_o,
  output logic                  irq_retrigger_o,
  output logic                  a20_gate_o,
  output logic                  reset_request_o,
  output logic                  unknown_command_o,
  output logic                  queue_overflow_o
);

  import ps2kc_pkg::*;

  // Queue pointers and controller state.
  logic [PTR_W-1:0]    rd_q [2];
  logic [CNT_W-1:0]    cnt_q [2];
  logic [7:0]          ram_q [RAM_BYTES];
  logic [7:0]          latch_q;
  logic                consumed_q;
  logic [7:0]          status_q;
  logic [1:0]          irq_q;
  logic [7:0]          pend_q;
  logic [7:0]          pmouse_q;
  logic                scan_q;
  logic                m_scaling_q, m_stream_q, m_inactive_q;
  logic [7:0]          m_res_q, m_rate_q;
  logic [2:0]          btn_q;
  logic signed [15:0]  accx_q, accy_q;
  logic                a20_q;
  logic [7:0]          rdout_q;
  logic                rst_q, unk_q, ovf_q, retrig_q;
  op_t                 ops_q [MAX_OPS];
  logic [OP_CNT_W-1:0] nops_q;
  logic                push_ok_q;

  // Decode results.
  logic [7:0]          status_dec, pend_dec, pmouse_dec, rd_dec;
  logic                scan_dec, m_scaling_dec, m_stream_dec, m_inactive_dec;
  logic [7:0]          m_res_dec, m_rate_dec;
  logic [2:0]          btn_dec;
  logic signed [15:0]  accx_dec, accy_dec;
  logic                a20_dec, consumed_dec, clear_dec, rst_dec, unk_dec;
  logic [1:0]          irq_dec;
  logic                ram_we_dec;
  logic [RAM_AW-1:0]   ram_waddr_dec;
  logic [7:0]          ram_wdata_dec;
  op_t                 ops_dec [MAX_OPS];
  logic [OP_CNT_W-1:0] n_dec;

  // Mouse motion and packet build.
  logic signed [16:0]  sumx, sumy, ny;
  logic signed [15:0]  satx, saty, pk_x, pk_y;
  logic [7:0]          pk_hdr, pk_dx, pk_dy;
  logic                ovfx, ovfy;

  // Queue memories.
  logic [7:0]          key_rdata, aux_rdata;
  op_t                 op_cur;
  logic                push_full, key_we, aux_we;
  logic [CNT_W:0]      wsum;
  logic [PTR_W-1:0]    waddr;

  // Refill results.
  logic                rf_any, rf_q, rf_pop, rf_cons, rf_rt;
  logic [7:0]          rf_status;
  logic [1:0]          rf_irq;

  assign status_o.n_ops = nops_q;

  // Saturating accumulation of motion.
  always_comb begin
    sumx = {accx_q[15], accx_q} + {item_i.move_x[15], item_i.move_x};
    sumy = {accy_q[15], accy_q} + {item_i.move_y[15], item_i.move_y};
    if (sumx[16] != sumx[15]) begin
      satx = sumx[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      satx = sumx[15:0];
    end
    if (sumy[16] != sumy[15]) begin
      saty = sumy[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      saty = sumy[15:0];
    end
  end

  // Button bits as this item leaves them.
  always_comb begin
    btn_dec = btn_q;
    if (item_i.mode == MODE_BUTTON) begin
      if (item_i.left_set) btn_dec[0] = item_i.left_down;
      if (item_i.middle_set) btn_dec[2] = item_i.middle_down;
      if (item_i.right_set) btn_dec[1] = item_i.right_down;
    end
  end

  // Three-byte movement packet with clamping to plus or minus 255.
  always_comb begin
    pk_x = (item_i.mode == MODE_MOVE) ? satx : accx_q;
    pk_y = (item_i.mode == MODE_MOVE) ? saty : accy_q;
    ny   = 17'sd0 - $signed({pk_y[15], pk_y});
    ovfx = 1'b0;
    ovfy = 1'b0;
    if (pk_x > 16'sd255) begin
      pk_dx = 8'hFF;
      ovfx  = 1'b1;
    end else if (pk_x < -16'sd255) begin
      pk_dx = 8'h01;
      ovfx  = 1'b1;
    end else begin
      pk_dx = pk_x[7:0];
    end
    if (ny > 17'sd255) begin
      pk_dy = 8'hFF;
      ovfy  = 1'b1;
    end else if (ny < -17'sd255) begin
      pk_dy = 8'h01;
      ovfy  = 1'b1;
    end else begin
      pk_dy = ny[7:0];
    end
    pk_hdr = PKT_BASE | {ovfy, ovfx, ny[16], pk_x[15], 1'b0, btn_dec};
  end

  // Item decode: immediate state changes and the list of queue operations.
  always_comb begin
    status_dec     = status_q;
    pend_dec       = pend_q;
    pmouse_dec     = pmouse_q;
    scan_dec       = scan_q;
    m_scaling_dec  = m_scaling_q;
    m_stream_dec   = m_stream_q;
    m_inactive_dec = m_inactive_q;
    m_res_dec      = m_res_q;
    m_rate_dec     = m_rate_q;
    accx_dec       = accx_q;
    accy_dec       = accy_q;
    a20_dec        = a20_q;
    irq_dec        = irq_q;
    consumed_dec   = consumed_q;
    clear_dec      = 1'b0;
    rd_dec         = 8'h00;
    rst_dec        = 1'b0;
    unk_dec        = 1'b0;
    ram_we_dec     = 1'b0;
    ram_waddr_dec  = '0;
    ram_wdata_dec  = ram_q[0];
    n_dec          = '0;
    for (int i = 0; i < MAX_OPS; i++) begin
      ops_dec[i] = mk_refill(1'b0, 1'b0);
    end

    unique case (item_i.mode)
      MODE_READ: begin
        if (item_i.port_select) begin
          status_dec = status_q & ~STAT_TIMEOUT;
          rd_dec     = status_dec;
        end else begin
          status_dec   = status_q & ~(STAT_AUX | STAT_OFULL);
          irq_dec      = 2'd0;
          rd_dec       = latch_q;
          consumed_dec = 1'b1;
          ops_dec[0]   = mk_refill(1'b0, 1'b0);
          n_dec        = OP_CNT_W'(1);
        end
      end

      MODE_WRITE: begin
        status_dec = status_q & ~STAT_CMD;
        if (item_i.port_select) begin
          // Command port.
          priority if (item_i.data >= 8'h20 && item_i.data <= 8'h3F) begin
            ops_dec[0] = mk_push(1'b0, (item_i.data[4:0] == 5'd0) ?
                                 (ram_q[0] | (status_dec & STAT_SYS)) :
                                 ram_q[item_i.data[RAM_AW-1:0]]);
            n_dec = OP_CNT_W'(1);
          end else if ((item_i.data >= 8'h60 && item_i.data <= 8'h7F) ||
                       (item_i.data >= 8'hD1 && item_i.data <= 8'hD4)) begin
            status_dec = status_dec | STAT_CMD;
            pend_dec   = item_i.data;
          end else if (item_i.data >= 8'hF0) begin
            rst_dec = ~item_i.data[0];
          end else if (item_i.data == 8'hA1 || item_i.data == 8'hA9 ||
                       item_i.data == 8'hAB) begin
            ops_dec[0] = mk_push(1'b0, 8'h00);
            n_dec      = OP_CNT_W'(1);
          end else if (item_i.data == 8'hA7 || item_i.data == 8'hA8) begin
            ram_we_dec    = 1'b1;
            ram_wdata_dec = (ram_q[0] & ~CB_AUX_OFF) | (item_i.data[0] ? CB_AUX_OFF : 8'h00);
            if (!item_i.data[0]) begin
              ops_dec[0] = mk_refill(1'b1, 1'b1);
              n_dec      = OP_CNT_W'(1);
            end
          end else if (item_i.data == 8'hAA) begin
            status_dec    = status_dec | STAT_SYS;
            ram_we_dec    = 1'b1;
            ram_wdata_dec = ram_q[0] | STAT_SYS;
            ops_dec[0]    = mk_push(1'b0, BYTE_SELFTEST);
            n_dec         = OP_CNT_W'(1);
          end else if (item_i.data == 8'hAD || item_i.data == 8'hAE) begin
            ram_we_dec    = 1'b1;
            ram_wdata_dec = (ram_q[0] & ~CB_KBD_OFF) | (item_i.data[0] ? CB_KBD_OFF : 8'h00);
            if (!item_i.data[0]) begin
              ops_dec[0] = mk_refill(1'b1, 1'b0);
              n_dec      = OP_CNT_W'(1);
            end
          end else if (item_i.data == 8'hC0) begin
            ops_dec[0] = mk_push(1'b0, BYTE_INPORT);
            n_dec      = OP_CNT_W'(1);
          end else begin
            unk_dec = 1'b1;
          end
        end else begin
          // Data port.
          pend_dec = 8'h00;
          priority if (pend_q == 8'h00) begin
            unique case (item_i.data)
              8'hED: begin
                ops_dec[0] = mk_push(1'b0, BYTE_ACK);
                pend_dec   = 8'hED;
                n_dec      = OP_CNT_W'(1);
              end
              8'hEE: begin
                ops_dec[0] = mk_push(1'b0, BYTE_ACK);
                n_dec      = OP_CNT_W'(1);
              end
              8'hF2: begin
                ops_dec[0] = mk_push(1'b0, BYTE_ACK);
                ops_dec[1] = mk_push(1'b0, 8'hAB);
                ops_dec[2] = mk_push(1'b0, BYTE_ID_LOW);
                n_dec      = OP_CNT_W'(3);
              end
              8'hF3, 8'hF0: begin
                pend_dec   = item_i.data;
                ops_dec[0] = mk_push(1'b0, BYTE_ACK);
                n_dec      = OP_CNT_W'(1);
              end
              8'hF4, 8'hF5: begin
                scan_dec   = item_i.data[0];
                ops_dec[0] = mk_push(1'b0, BYTE_ACK);
                n_dec      = OP_CNT_W'(1);
              end
              8'hF6: begin
                clear_dec      = 1'b1;
                consumed_dec   = 1'b1;
                status_dec     = STAT_RESET;
                scan_dec       = 1'b0;
                ram_we_dec     = 1'b1;
                ram_wdata_dec  = CB_DEFAULT;
                m_scaling_dec  = 1'b0;
                m_stream_dec   = 1'b1;
                m_inactive_dec = 1'b1;
                m_res_dec      = MOUSE_RES_DEFAULT;
                m_rate_dec     = MOUSE_RATE_DEFAULT;
                ops_dec[0]     = mk_push(1'b0, BYTE_ACK);
                n_dec          = OP_CNT_W'(1);
              end
              8'hFF: begin
                scan_dec      = 1'b0;
                ram_we_dec    = 1'b1;
                ram_wdata_dec = CB_DEFAULT;
                ops_dec[0]    = mk_push(1'b0, BYTE_ACK);
                ops_dec[1]    = mk_push(1'b0, BYTE_BAT_OK);
                n_dec         = OP_CNT_W'(2);
              end
              8'h05: begin
                ops_dec[0] = mk_push(1'b0, BYTE_RESEND);
                n_dec      = OP_CNT_W'(1);
              end
              8'hFA, 8'hE8: begin
                ops_dec[0] = mk_push(1'b1, BYTE_RESEND);
                n_dec      = OP_CNT_W'(1);
              end
              default: unk_dec = 1'b1;
            endcase
          end else if (pend_q >= 8'h60 && pend_q <= 8'h7F) begin
            ram_we_dec    = 1'b1;
            ram_waddr_dec = pend_q[RAM_AW-1:0];
            ram_wdata_dec = item_i.data;
            ops_dec[0]    = mk_refill(1'b0, 1'b0);
            n_dec         = OP_CNT_W'(1);
          end else if (pend_q == 8'hD1) begin
            a20_dec = item_i.data[1];
          end else if (pend_q == 8'hD2) begin
            ops_dec[0] = mk_push(1'b0, item_i.data);
            n_dec      = OP_CNT_W'(1);
          end else if (pend_q == 8'hD3) begin
            ops_dec[0] = mk_push(1'b1, item_i.data);
            n_dec      = OP_CNT_W'(1);
          end else if (pend_q == 8'hD4) begin
            // Byte forwarded to the mouse.
            priority if (pmouse_q == 8'hE8 || pmouse_q == 8'hF3) begin
              if (pmouse_q == 8'hE8) begin
                m_res_dec = item_i.data;
              end else begin
                m_rate_dec = item_i.data;
              end
              ops_dec[0] = mk_push(1'b1, BYTE_ACK);
              pmouse_dec = 8'h00;
              n_dec      = OP_CNT_W'(1);
            end else if (pmouse_q != 8'h00) begin
              pmouse_dec = pmouse_q;
            end else begin
              unique case (item_i.data)
                8'hE6, 8'hE7: begin
                  m_scaling_dec = item_i.data[0];
                  ops_dec[0]    = mk_push(1'b1, BYTE_ACK);
                  n_dec         = OP_CNT_W'(1);
                end
                8'hE8, 8'hF3: begin
                  pmouse_dec = item_i.data;
                  ops_dec[0] = mk_push(1'b1, BYTE_ACK);
                  n_dec      = OP_CNT_W'(1);
                end
                8'hE9: begin
                  ops_dec[0] = mk_push(1'b1, BYTE_ACK);
                  ops_dec[1] = mk_push(1'b1, {1'b0, m_stream_q, ~m_inactive_q,
                                              ~m_scaling_q, 1'b0, btn_q});
                  ops_dec[2] = mk_push(1'b1, m_res_q);
                  ops_dec[3] = mk_push(1'b1, m_rate_q);
                  n_dec      = OP_CNT_W'(4);
                end
                8'hEA: begin
                  m_stream_dec = 1'b1;
                  ops_dec[0]   = mk_push(1'b1, BYTE_ACK);
                  n_dec        = OP_CNT_W'(1);
                end
                8'hF2: begin
                  ops_dec[0] = mk_push(1'b1, BYTE_ACK);
                  ops_dec[1] = mk_push(1'b1, 8'h00);
                  n_dec      = OP_CNT_W'(2);
                end
                8'hF4, 8'hF5: begin
                  m_inactive_dec = item_i.data[0];
                  ops_dec[0]     = mk_push(1'b1, BYTE_ACK);
                  n_dec          = OP_CNT_W'(1);
                end
                8'hF6: begin
                  m_scaling_dec  = 1'b0;
                  m_stream_dec   = 1'b1;
                  m_inactive_dec = 1'b1;
                  m_res_dec      = MOUSE_RES_DEFAULT;
                  m_rate_dec     = MOUSE_RATE_DEFAULT;
                  ops_dec[0]     = mk_push(1'b1, BYTE_ACK);
                  n_dec          = OP_CNT_W'(1);
                end
                8'hFF: begin
                  m_scaling_dec  = 1'b0;
                  m_stream_dec   = 1'b1;
                  m_inactive_dec = 1'b1;
                  m_res_dec      = MOUSE_RES_DEFAULT;
                  m_rate_dec     = MOUSE_RATE_DEFAULT;
                  ops_dec[0]     = mk_push(1'b1, BYTE_ACK);
                  ops_dec[1]     = mk_push(1'b1, BYTE_BAT_OK);
                  ops_dec[2]     = mk_push(1'b1, 8'h00);
                  n_dec          = OP_CNT_W'(3);
                end
                8'hBB: begin
                  pmouse_dec = 8'h00;
                end
                8'hE1, 8'h0A, 8'h88, 8'h00: begin
                  ops_dec[0] = mk_push(1'b1, BYTE_RESEND);
                  n_dec      = OP_CNT_W'(1);
                end
                default: unk_dec = 1'b1;
              endcase
            end
          end else if (pend_q == 8'hED || pend_q == 8'hF3) begin
            ops_dec[0] = mk_push(1'b0, BYTE_ACK);
            n_dec      = OP_CNT_W'(1);
          end else if (pend_q == 8'hF0) begin
            ops_dec[0] = mk_push(1'b0, BYTE_ACK);
            ops_dec[1] = mk_push(1'b0, 8'h02);
            n_dec      = (item_i.data == 8'h00) ? OP_CNT_W'(2) : OP_CNT_W'(1);
          end else begin
            unk_dec = 1'b1;
          end
        end
      end

      MODE_KEY: begin
        if (!scan_q) begin
          ops_dec[0] = mk_push(1'b0, item_i.data);
          n_dec      = OP_CNT_W'(1);
        end
      end

      MODE_MOVE: begin
        if (m_stream_q && !m_inactive_q) begin
          accx_dec = satx;
          accy_dec = saty;
          if (cnt_q[1] == '0 && (satx != 16'sd0 || saty != 16'sd0)) begin
            ops_dec[0] = mk_push(1'b1, pk_hdr);
            ops_dec[1] = mk_push(1'b1, pk_dx);
            ops_dec[2] = mk_push(1'b1, pk_dy);
            n_dec      = OP_CNT_W'(3);
            accx_dec   = 16'sd0;
            accy_dec   = 16'sd0;
          end
        end
      end

      MODE_BUTTON: begin
        if (btn_dec != btn_q) begin
          ops_dec[0] = mk_push(1'b1, pk_hdr);
          ops_dec[1] = mk_push(1'b1, pk_dx);
          ops_dec[2] = mk_push(1'b1, pk_dy);
          n_dec      = OP_CNT_W'(3);
          accx_dec   = 16'sd0;
          accy_dec   = 16'sd0;
        end
      end

      default: begin
        n_dec = '0;
      end
    endcase
  end

  // Push step: write address and full check.
  always_comb begin
    op_cur    = ops_q[cmd_i.idx];
    push_full = (cnt_q[op_cur.q] >= CNT_W'(QUEUE_DEPTH));
    wsum      = (CNT_W + 1)'(rd_q[op_cur.q]) + (CNT_W + 1)'(cnt_q[op_cur.q]);
    if (wsum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      waddr = PTR_W'(wsum - (CNT_W + 1)'(QUEUE_DEPTH));
    end else begin
      waddr = PTR_W'(wsum);
    end
    key_we = cmd_i.act && (op_cur.kind == OP_PUSH) && !push_full && !op_cur.q;
    aux_we = cmd_i.act && (op_cur.kind == OP_PUSH) && !push_full && op_cur.q;
  end

  // Refill step: move the head of the first non-empty queue into the latch.
  always_comb begin
    rf_any    = (cnt_q[0] != '0) || (cnt_q[1] != '0);
    rf_q      = (cnt_q[0] == '0);
    rf_pop    = 1'b0;
    rf_cons   = consumed_q;
    rf_status = status_q;
    rf_irq    = irq_q;
    rf_rt     = 1'b0;
    if (rf_any) begin
      if (consumed_q) begin
        rf_pop  = 1'b1;
        rf_cons = 1'b0;
      end
      rf_status    = rf_status | STAT_OFULL;
      rf_status[5] = rf_q;
      if (ram_q[0][rf_q]) begin
        rf_irq = rf_q ? 2'd2 : 2'd1;
        rf_rt  = 1'b1;
      end
    end
    // Re-enable commands raise the interrupt again while the latch is full.
    if (op_cur.raise && !rf_cons) begin
      rf_status    = rf_status | STAT_OFULL;
      rf_status[5] = op_cur.q;
      if (ram_q[0][op_cur.q]) begin
        rf_irq = op_cur.q ? 2'd2 : 2'd1;
        rf_rt  = 1'b1;
      end
    end
  end

  ps2kc_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (op_cur.value),
    .raddr_i (rd_q[0]),
    .rdata_o (key_rdata)
  );

  ps2kc_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_aux_ram (
    .clk_i   (clk_i),
    .we_i    (aux_we),
    .waddr_i (waddr),
    .wdata_i (op_cur.value),
    .raddr_i (rd_q[1]),
    .rdata_o (aux_rdata)
  );

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        rd_q[i]  <= '0;
        cnt_q[i] <= '0;
      end
      for (int i = 0; i < RAM_BYTES; i++) begin
        ram_q[i] <= '0;
      end
      ram_q[0]     <= CB_DEFAULT;
      latch_q      <= '0;
      consumed_q   <= 1'b1;
      status_q     <= STAT_RESET;
      irq_q        <= '0;
      pend_q       <= '0;
      pmouse_q     <= '0;
      scan_q       <= 1'b0;
      m_scaling_q  <= 1'b0;
      m_stream_q   <= 1'b1;
      m_inactive_q <= 1'b1;
      m_res_q      <= MOUSE_RES_DEFAULT;
      m_rate_q     <= MOUSE_RATE_DEFAULT;
      btn_q        <= '0;
      accx_q       <= '0;
      accy_q       <= '0;
      a20_q        <= 1'b0;
      rdout_q      <= '0;
      rst_q        <= 1'b0;
      unk_q        <= 1'b0;
      ovf_q        <= 1'b0;
      retrig_q     <= 1'b0;
      for (int i = 0; i < MAX_OPS; i++) begin
        ops_q[i] <= mk_refill(1'b0, 1'b0);
      end
      nops_q       <= '0;
      push_ok_q    <= 1'b0;
    end else if (cmd_i.decode) begin
      status_q     <= status_dec;
      pend_q       <= pend_dec;
      pmouse_q     <= pmouse_dec;
      scan_q       <= scan_dec;
      m_scaling_q  <= m_scaling_dec;
      m_stream_q   <= m_stream_dec;
      m_inactive_q <= m_inactive_dec;
      m_res_q      <= m_res_dec;
      m_rate_q     <= m_rate_dec;
      btn_q        <= btn_dec;
      accx_q       <= accx_dec;
      accy_q       <= accy_dec;
      a20_q        <= a20_dec;
      irq_q        <= irq_dec;
      consumed_q   <= consumed_dec;
      rdout_q      <= rd_dec;
      rst_q        <= rst_dec;
      unk_q        <= unk_dec;
      ovf_q        <= 1'b0;
      retrig_q     <= 1'b0;
      for (int i = 0; i < MAX_OPS; i++) begin
        ops_q[i] <= ops_dec[i];
      end
      nops_q <= n_dec;
      if (ram_we_dec) begin
        ram_q[ram_waddr_dec] <= ram_wdata_dec;
      end
      if (clear_dec) begin
        for (int i = 0; i < 2; i++) begin
          rd_q[i]  <= '0;
          cnt_q[i] <= '0;
        end
      end
    end else if (cmd_i.act) begin
      if (op_cur.kind == OP_PUSH) begin
        if (push_full) begin
          ovf_q     <= 1'b1;
          push_ok_q <= 1'b0;
        end else begin
          cnt_q[op_cur.q] <= cnt_q[op_cur.q] + CNT_W'(1);
          push_ok_q       <= 1'b1;
        end
      end else begin
        push_ok_q <= 1'b1;
      end
    end else if (cmd_i.fin && push_ok_q) begin
      consumed_q <= rf_cons;
      status_q   <= rf_status;
      irq_q      <= rf_irq;
      if (rf_rt) begin
        retrig_q <= 1'b1;
      end
      if (rf_pop) begin
        latch_q      <= rf_q ? aux_rdata : key_rdata;
        cnt_q[rf_q]  <= cnt_q[rf_q] - CNT_W'(1);
        rd_q[rf_q]   <= (rd_q[rf_q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                        rd_q[rf_q] + PTR_W'(1);
      end
    end
  end

  assign read_data_o       = rdout_q;
  assign irq_line_o        = irq_q;
  assign irq_retrigger_o   = retrig_q;
  assign a20_gate_o        = a20_q;
  assign reset_request_o   = rst_q;
  assign unknown_command_o = unk_q;
  assign queue_overflow_o  = ovf_q;

endmodule

FILE: src/ps2_keyboard_mouse_controller.sv
// PS/2 keyboard and mouse controller in the style of the 8042. An item is
// taken when start_i is high and busy_o is low; its result appears on the
// result ports for exactly one cycle with done_o high, and the receiver
// cannot hold it off, so sample it on that cycle. An item moves n bytes
// through the queues (n from 0 to 4), one step per queue push or latch
// refill: the write, a settle state because the keyboard and aux queue
// memories have a registered read port, the latch update, and the check for
// the next step.
module ps2_keyboard_mouse_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         mode_i,
  input  logic               port_select_i,
  input  logic [7:0]         data_i,
  input  logic signed [15:0] move_x_i,
  input  logic signed [15:0] move_y_i,
  input  logic               left_set_i,
  input  logic               left_down_i,
  input  logic               middle_set_i,
  input  logic               middle_down_i,
  input  logic               right_set_i,
  input  logic               right_down_i,
  output logic               done_o,
  output logic [7:0]         read_data_o,
  output logic [1:0]         irq_line_o,
  output logic               irq_retrigger_o,
  output logic               a20_gate_o,
  output logic               reset_request_o,
  output logic               unknown_command_o,
  output logic               queue_overflow_o
);

  import ps2kc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  item_t      item;

  // Bundle the input beat.
  always_comb begin
    item.mode        = mode_i;
    item.port_select = port_select_i;
    item.data        = data_i;
    item.move_x      = move_x_i;
    item.move_y      = move_y_i;
    item.left_set    = left_set_i;
    item.left_down   = left_down_i;
    item.middle_set  = middle_set_i;
    item.middle_down = middle_down_i;
    item.right_set   = right_set_i;
    item.right_down  = right_down_i;
  end

  ps2kc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  ps2kc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .item_i            (item),
    .read_data_o       (read_data_o),
    .irq_line_o        (irq_line_o),
    .irq_retrigger_o   (irq_retrigger_o),
    .a20_gate_o        (a20_gate_o),
    .reset_request_o   (reset_request_o),
    .unknown_command_o (unknown_command_o),
    .queue_overflow_o  (queue_overflow_o)
  );

endmodule

FILE: dv/ps2kc_checker.sv
`timescale 1ns / 100ps

module ps2kc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  ps2kc_pkg::item_t   item_i,
  input  logic               done_i,
  input  logic [7:0]         read_data_i,
  input  logic [1:0]         irq_line_i,
  input  logic               irq_retrigger_i,
  input  logic               a20_gate_i,
  input  logic               reset_request_i,
  input  logic               unknown_command_i,
  input  logic               queue_overflow_i,
  output int                 fail_count_o,
  output int                 replies_due_o
);

  import ps2kc_pkg::*;

  typedef struct {
    logic [7:0] rdata;
    logic [1:0] irq;
    logic       retrig;
    logic       a20;
    logic       rst_req;
    logic       unk;
    logic       ovf;
  } ctrl_reply_t;

  ctrl_reply_t replies_due[$];

  // Shadow copy of the controller state.
  logic [7:0] kbd_mem [QUEUE_DEPTH];
  logic [7:0] aux_mem [QUEUE_DEPTH];
  int         rd_ptr [2];
  int         fill [2];
  logic [7:0] cram [RAM_BYTES];
  logic [7:0] out_latch;
  bit         latch_free;
  logic [7:0] status;
  logic [1:0] irq_now;
  logic [7:0] cmd_wait;
  logic [7:0] mouse_wait;
  bit         scan_off;
  bit         m_scaling, m_stream, m_inactive;
  logic [7:0] m_res, m_rate;
  logic [2:0] buttons;
  int         acc_x, acc_y;
  bit         a20_lvl;
  bit         saw_retrig, saw_ovf, saw_rst;

  assign replies_due_o = replies_due.size();

  function automatic void mouse_defaults();
    m_scaling  = 1'b0;
    m_stream   = 1'b1;
    m_inactive = 1'b1;
    m_res      = MOUSE_RES_DEFAULT;
    m_rate     = MOUSE_RATE_DEFAULT;
  endfunction

  function automatic void ctrl_clear();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      kbd_mem[i] = '0;
      aux_mem[i] = '0;
    end
    for (int i = 0; i < RAM_BYTES; i++) cram[i] = '0;
    rd_ptr = '{0, 0};
    fill = '{0, 0};
    out_latch = '0;
    latch_free = 1'b1;
    status = STAT_RESET;
    irq_now = '0;
    cmd_wait = '0;
    mouse_wait = '0;
    scan_off = 1'b0;
    cram[0] = CB_DEFAULT;
    mouse_defaults();
    buttons = '0;
    acc_x = 0;
    acc_y = 0;
    a20_lvl = 1'b0;
  endfunction

  function automatic logic [7:0] fifo_pop(int q);
    logic [7:0] v;
    v = q ? aux_mem[rd_ptr[q]] : kbd_mem[rd_ptr[q]];
    rd_ptr[q] = (rd_ptr[q] + 1) % QUEUE_DEPTH;
    fill[q]--;
    return v;
  endfunction

  function automatic void irq_raise(int aux);
    status |= STAT_OFULL;
    if (aux != 0) status |= STAT_AUX;
    else status &= ~STAT_AUX;
    if (cram[0] & (aux ? 8'h02 : 8'h01)) begin
      irq_now = aux ? 2'd2 : 2'd1;
      saw_retrig = 1'b1;
    end
  endfunction

  // Keyboard bytes always go ahead of aux bytes into the latch.
  function automatic void latch_refill();
    int q;
    if (fill[0] != 0) q = 0;
    else if (fill[1] != 0) q = 1;
    else return;
    if (latch_free) begin
      latch_free = 1'b0;
      out_latch = fifo_pop(q);
    end
    irq_raise(q);
  endfunction

  function automatic void fifo_push(int q, logic [7:0] v);
    if (fill[q] >= QUEUE_DEPTH) begin
      saw_ovf = 1'b1;
      return;
    end
    if (q != 0) aux_mem[(rd_ptr[q] + fill[q]) % QUEUE_DEPTH] = v;
    else kbd_mem[(rd_ptr[q] + fill[q]) % QUEUE_DEPTH] = v;
    fill[q]++;
    latch_refill();
  endfunction

  function automatic int clamp_delta(int v, logic [7:0] ovf_bit, inout logic [7:0] hdr);
    if (v > 255) begin
      hdr |= ovf_bit;
      return 255;
    end
    if (v < -255) begin
      hdr |= ovf_bit;
      return -255;
    end
    return v;
  endfunction

  function automatic int sat16(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  // Three-byte movement packet; y is negated into the packet.
  function automatic void motion_packet(bit clicked);
    logic [7:0] hdr;
    int dx, dy;
    if (!clicked && acc_x == 0 && acc_y == 0) return;
    hdr = PKT_BASE;
    dx = clamp_delta(acc_x, 8'h40, hdr);
    dy = clamp_delta(-acc_y, 8'h80, hdr);
    if (dy < 0) hdr |= 8'h20;
    if (dx < 0) hdr |= 8'h10;
    hdr |= {5'd0, buttons};
    fifo_push(1, hdr);
    fifo_push(1, dx[7:0]);
    fifo_push(1, dy[7:0]);
    acc_x = 0;
    acc_y = 0;
  endfunction

  function automatic bit mouse_cmd(logic [7:0] d);
    if (mouse_wait == 8'hE8 || mouse_wait == 8'hF3) begin
      if (mouse_wait == 8'hE8) m_res = d;
      else m_rate = d;
      fifo_push(1, BYTE_ACK);
      mouse_wait = '0;
      return 1'b1;
    end
    if (mouse_wait != 0) return 1'b1;
    case (d)
      8'hE6, 8'hE7: begin
        m_scaling = d[0];
        fifo_push(1, BYTE_ACK);
      end
      8'hE8, 8'hF3: begin
        mouse_wait = d;
        fifo_push(1, BYTE_ACK);
      end
      8'hE9: begin
        fifo_push(1, BYTE_ACK);
        fifo_push(1, {1'b0, m_stream, ~m_inactive, ~m_scaling, 1'b0, buttons});
        fifo_push(1, m_res);
        fifo_push(1, m_rate);
      end
      8'hEA: begin
        m_stream = 1'b1;
        fifo_push(1, BYTE_ACK);
      end
      8'hF2: begin
        fifo_push(1, BYTE_ACK);
        fifo_push(1, 8'h00);
      end
      8'hF4, 8'hF5: begin
        m_inactive = d[0];
        fifo_push(1, BYTE_ACK);
      end
      8'hF6: begin
        mouse_defaults();
        fifo_push(1, BYTE_ACK);
      end
      8'hFF: begin
        mouse_defaults();
        fifo_push(1, BYTE_ACK);
        fifo_push(1, BYTE_BAT_OK);
        fifo_push(1, 8'h00);
      end
      8'hBB: ;
      8'hE1, 8'h0A, 8'h88, 8'h00: fifo_push(1, BYTE_RESEND);
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit command_write(logic [7:0] d);
    status &= ~STAT_CMD;
    if (d >= 8'h20 && d <= 8'h3F) begin
      if (d[4:0] == 0) fifo_push(0, cram[0] | (status & STAT_SYS));
      else fifo_push(0, cram[d[4:0]]);
    end else if ((d >= 8'h60 && d <= 8'h7F) || (d >= 8'hD1 && d <= 8'hD4)) begin
      status |= STAT_CMD;
      cmd_wait = d;
    end else if (d >= 8'hF0) begin
      if (!d[0]) saw_rst = 1'b1;
    end else if (d == 8'hA1 || d == 8'hA9 || d == 8'hAB) begin
      fifo_push(0, 8'h00);
    end else if (d == 8'hA7 || d == 8'hA8) begin
      cram[0] = (cram[0] & ~CB_AUX_OFF) | (d[0] ? CB_AUX_OFF : 8'h00);
      if (!(cram[0] & CB_AUX_OFF)) begin
        latch_refill();
        if (!latch_free) irq_raise(1);
      end
    end else if (d == 8'hAA) begin
      status |= STAT_SYS;
      cram[0] |= STAT_SYS;
      fifo_push(0, BYTE_SELFTEST);
    end else if (d == 8'hAD || d == 8'hAE) begin
      cram[0] = (cram[0] & ~CB_KBD_OFF) | (d[0] ? CB_KBD_OFF : 8'h00);
      if (!(cram[0] & CB_KBD_OFF)) begin
        latch_refill();
        if (!latch_free) irq_raise(0);
      end
    end else if (d == 8'hC0) begin
      fifo_push(0, BYTE_INPORT);
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit data_write(logic [7:0] d);
    logic [7:0] c;
    c = cmd_wait;
    status &= ~STAT_CMD;
    cmd_wait = '0;
    if (c == 0) begin
      case (d)
        8'hED: begin
          fifo_push(0, BYTE_ACK);
          cmd_wait = 8'hED;
        end
        8'hEE: fifo_push(0, BYTE_ACK);
        8'hF2: begin
          fifo_push(0, BYTE_ACK);
          fifo_push(0, 8'hAB);
          fifo_push(0, BYTE_ID_LOW);
        end
        8'hF3, 8'hF0: begin
          cmd_wait = d;
          fifo_push(0, BYTE_ACK);
        end
        8'hF4, 8'hF5: begin
          scan_off = d[0];
          fifo_push(0, BYTE_ACK);
        end
        8'hF6: begin
          rd_ptr = '{0, 0};
          fill = '{0, 0};
          latch_free = 1'b1;
          status = STAT_RESET;
          scan_off = 1'b0;
          cram[0] = CB_DEFAULT;
          mouse_defaults();
          fifo_push(0, BYTE_ACK);
        end
        8'hFF: begin
          scan_off = 1'b0;
          cram[0] = CB_DEFAULT;
          fifo_push(0, BYTE_ACK);
          fifo_push(0, BYTE_BAT_OK);
        end
        8'h05: fifo_push(0, BYTE_RESEND);
        8'hFA, 8'hE8: fifo_push(1, BYTE_RESEND);
        default: return 1'b0;
      endcase
      return 1'b1;
    end
    if (c >= 8'h60 && c <= 8'h7F) begin
      cram[c[4:0]] = d;
      latch_refill();
    end else if (c == 8'hD1) a20_lvl = d[1];
    else if (c == 8'hD2) fifo_push(0, d);
    else if (c == 8'hD3) fifo_push(1, d);
    else if (c == 8'hD4) return mouse_cmd(d);
    else if (c == 8'hED || c == 8'hF3) fifo_push(0, BYTE_ACK);
    else if (c == 8'hF0) begin
      fifo_push(0, BYTE_ACK);
      if (d == 0) fifo_push(0, 8'h02);
    end else return 1'b0;
    return 1'b1;
  endfunction

  // Works out the reply for one accepted beat and updates the shadow state.
  function automatic ctrl_reply_t ctrl_access(item_t it);
    ctrl_reply_t r;
    logic [2:0] old_btn;
    r = '{default: '0};
    saw_retrig = 1'b0;
    saw_ovf = 1'b0;
    saw_rst = 1'b0;
    case (it.mode)
      MODE_READ: begin
        if (it.port_select) begin
          status &= ~STAT_TIMEOUT;
          r.rdata = status;
        end else begin
          status &= ~(STAT_AUX | STAT_OFULL);
          irq_now = '0;
          r.rdata = out_latch;
          latch_free = 1'b1;
          latch_refill();
        end
      end
      MODE_WRITE: r.unk = it.port_select ? !command_write(it.data) : !data_write(it.data);
      MODE_KEY: if (!scan_off) fifo_push(0, it.data);
      MODE_MOVE: begin
        if (m_stream && !m_inactive) begin
          acc_x = sat16(acc_x + int'(it.move_x));
          acc_y = sat16(acc_y + int'(it.move_y));
          if (fill[1] == 0) motion_packet(1'b0);
        end
      end
      MODE_BUTTON: begin
        old_btn = buttons;
        if (it.left_set) buttons[0] = it.left_down;
        if (it.middle_set) buttons[2] = it.middle_down;
        if (it.right_set) buttons[1] = it.right_down;
        if (old_btn != buttons) motion_packet(1'b1);
      end
      default: ;
    endcase
    r.irq = irq_now;
    r.retrig = saw_retrig;
    r.a20 = a20_lvl;
    r.rst_req = saw_rst;
    r.ovf = saw_ovf;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
    $display("%0t: mismatch on %s: got 0x%02h, expected 0x%02h", $realtime, field, got, want);
    fail_count_o++;
  endtask

  // Compare each reply beat with the oldest prediction, then predict for a new beat.
  always @(posedge clk_i or negedge rst_ni) begin
    ctrl_reply_t w;
    if (!rst_ni) begin
      ctrl_clear();
      replies_due.delete();
      fail_count_o = 0;
    end else begin
      if (done_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: reply beat with no item outstanding", $realtime);
          fail_count_o++;
        end else begin
          w = replies_due.pop_front();
          if (read_data_i !== w.rdata) report_mismatch("read_data", read_data_i, w.rdata);
          if (irq_line_i !== w.irq) report_mismatch("irq_line", irq_line_i, w.irq);
          if (irq_retrigger_i !== w.retrig)
            report_mismatch("irq_retrigger", irq_retrigger_i, w.retrig);
          if (a20_gate_i !== w.a20) report_mismatch("a20_gate", a20_gate_i, w.a20);
          if (reset_request_i !== w.rst_req)
            report_mismatch("reset_request", reset_request_i, w.rst_req);
          if (unknown_command_i !== w.unk)
            report_mismatch("unknown_command", unknown_command_i, w.unk);
          if (queue_overflow_i !== w.ovf)
            report_mismatch("queue_overflow", queue_overflow_i, w.ovf);
        end
      end
      if (start_i && !busy_i) replies_due.push_back(ctrl_access(item_i));
    end
  end

  // Anything still waiting at the end is flagged by the top through replies_due_o.

endmodule

FILE: dv/tb_ps2_keyboard_mouse_controller.sv
`timescale 1ns / 100ps

module tb_ps2_keyboard_mouse_controller;
  import ps2kc_pkg::*;

  localparam int ITEM_W = $bits(item_t);

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  item_t item;
  logic  done;
  logic [7:0] read_data;
  logic [1:0] irq_line;
  logic  irq_retrigger, a20_gate, reset_request, unknown_command, queue_overflow;
  int    fail_count;
  int    replies_due;
  int    idle_cycles;
  int    gap_max;

  localparam int WATCHDOG_LIMIT = 4000;

  ps2_keyboard_mouse_controller dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .mode_i(item.mode), .port_select_i(item.port_select), .data_i(item.data),
    .move_x_i(item.move_x), .move_y_i(item.move_y),
    .left_set_i(item.left_set), .left_down_i(item.left_down),
    .middle_set_i(item.middle_set), .middle_down_i(item.middle_down),
    .right_set_i(item.right_set), .right_down_i(item.right_down),
    .done_o(done), .read_data_o(read_data), .irq_line_o(irq_line),
    .irq_retrigger_o(irq_retrigger), .a20_gate_o(a20_gate),
    .reset_request_o(reset_request), .unknown_command_o(unknown_command),
    .queue_overflow_o(queue_overflow)
  );

  ps2kc_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .item_i(item),
    .done_i(done), .read_data_i(read_data), .irq_line_i(irq_line),
    .irq_retrigger_i(irq_retrigger), .a20_gate_i(a20_gate),
    .reset_request_i(reset_request), .unknown_command_i(unknown_command),
    .queue_overflow_i(queue_overflow), .fail_count_o(fail_count),
    .replies_due_o(replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic item_t noise_item();
    item_t it;
    it = item_t'(ITEM_W'({$urandom, $urandom}));
    return it;
  endfunction

  // Drives one item at a falling edge after a random gap and holds it until taken.
  // Start was released at the previous falling edge, so the first wait moves past it.
  task automatic send_item(item_t it);
    int gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    repeat (gap) @(negedge clk);
    start <= 1'b1;
    item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic send_op(logic [2:0] mode, logic port, logic [7:0] d);
    item_t it;
    it = noise_item();
    it.mode = mode;
    it.port_select = port;
    it.data = d;
    send_item(it);
  endtask

  task automatic send_move(logic signed [15:0] dx, logic signed [15:0] dy);
    item_t it;
    it = noise_item();
    it.mode = MODE_MOVE;
    it.move_x = dx;
    it.move_y = dy;
    send_item(it);
  endtask

  task automatic send_cmd_pair(logic [7:0] c, logic [7:0] d);
    send_op(MODE_WRITE, 1'b1, c);
    send_op(MODE_WRITE, 1'b0, d);
  endtask

  function automatic logic [7:0] mouse_byte_pick();
    logic [7:0] codes [16] = '{8'hE6, 8'hE7, 8'hE8, 8'hF3, 8'hE9, 8'hEA, 8'hF2, 8'hF4,
                               8'hF5, 8'hF6, 8'hFF, 8'hBB, 8'hE1, 8'h0A, 8'h88, 8'h00};
    if ($urandom_range(0, 5) == 0) return 8'($urandom);
    if ($urandom_range(0, 2) == 0) return 8'hF4;
    return codes[$urandom_range(0, 15)];
  endfunction

  function automatic logic [7:0] cmd_pick();
    logic [7:0] codes [12] = '{8'h20, 8'hAA, 8'hC0, 8'hA1, 8'hA9, 8'hAB, 8'hA7, 8'hA8,
                               8'hAD, 8'hAE, 8'hF1, 8'hFE};
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h20, 8'h3F));
    return codes[$urandom_range(0, 11)];
  endfunction

  function automatic logic [7:0] kbd_pick();
    logic [7:0] codes [12] = '{8'hED, 8'hEE, 8'hF2, 8'hF3, 8'hF0, 8'hF4, 8'hF5, 8'hF6,
                               8'hFF, 8'h05, 8'hFA, 8'hE8};
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return codes[$urandom_range(0, 11)];
  endfunction

  function automatic logic signed [15:0] delta_pick();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 800)) - 400);
    endcase
  endfunction

  // One random step: mostly well-formed exchanges with random content.
  task automatic random_step();
    int pick;
    item_t it;
    pick = $urandom_range(0, 99);
    if (pick < 30) send_op(MODE_READ, $urandom_range(0, 3) == 0, 8'($urandom));
    else if (pick < 38) send_op(MODE_KEY, 1'b0, 8'($urandom));
    else if (pick < 46) send_op(MODE_WRITE, 1'b1, cmd_pick());
    else if (pick < 54) send_op(MODE_WRITE, 1'b0, kbd_pick());
    else if (pick < 66) send_cmd_pair(8'hD4, mouse_byte_pick());
    else if (pick < 70) send_cmd_pair(8'($urandom_range(8'h60, 8'h7F)),
                                      $urandom_range(0, 1) ? 8'($urandom) : CB_DEFAULT | 8'h02);
    else if (pick < 74) send_cmd_pair(8'($urandom_range(8'hD1, 8'hD3)), 8'($urandom));
    else if (pick < 86) send_move(delta_pick(), delta_pick());
    else if (pick < 94) begin
      it = noise_item();
      it.mode = MODE_BUTTON;
      send_item(it);
    end else if (pick < 97) begin
      it = noise_item();
      it.mode = 3'($urandom_range(5, 7));
      send_item(it);
    end else send_item(noise_item());
  endtask

  initial begin
    item_t it;
    start = 1'b0;
    item = '0;
    rst_n = 1'b0;
    gap_max = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: each command family, field extremes, an unused mode.
    send_op(MODE_READ, 1'b1, 8'h00);
    send_op(MODE_WRITE, 1'b1, 8'h20);
    send_op(MODE_READ, 1'b0, 8'h00);
    send_op(MODE_WRITE, 1'b1, 8'hAA);
    send_op(MODE_WRITE, 1'b1, 8'hC0);
    send_op(MODE_WRITE, 1'b1, 8'h3F);
    send_cmd_pair(8'h60, 8'h07);
    send_cmd_pair(8'hD1, 8'h02);
    send_cmd_pair(8'hD4, 8'hF4);
    send_move(16'sh7FFF, -16'sh8000);
    send_move(16'sh7FFF, 16'sh7FFF);
    send_op(MODE_READ, 1'b0, 8'hFF);
    send_cmd_pair(8'hD3, 8'hFF);
    send_op(MODE_WRITE, 1'b1, 8'hA7);
    send_op(MODE_WRITE, 1'b1, 8'hA8);
    send_op(MODE_WRITE, 1'b1, 8'hAD);
    send_op(MODE_WRITE, 1'b1, 8'hAE);
    send_op(MODE_WRITE, 1'b0, 8'hF0);
    send_op(MODE_WRITE, 1'b0, 8'h00);
    send_op(MODE_WRITE, 1'b0, 8'hF2);
    send_op(MODE_WRITE, 1'b1, 8'hFE);
    send_op(MODE_WRITE, 1'b1, 8'hF1);
    send_op(MODE_WRITE, 1'b1, 8'h10);
    send_op(MODE_WRITE, 1'b0, 8'h12);
    it = noise_item();
    it.mode = 3'd7;
    send_item(it);
    send_op(MODE_WRITE, 1'b0, 8'hF6);

    // Random part, in phases of differing sender pace.
    for (int phase = 0; phase < 6; phase++) begin
      gap_max = (phase % 3 == 0) ? 0 : 8;
      for (int n = 0; n < 50; n++) random_step();
      if (phase == 3) begin
        while (replies_due != 0) @(negedge clk);
        // Fill both queues past their depth.
        send_op(MODE_WRITE, 1'b0, 8'hF4);
        gap_max = 0;
        for (int n = 0; n < QUEUE_DEPTH + 4; n++) send_op(MODE_KEY, 1'b0, 8'($urandom));
        for (int n = 0; n < QUEUE_DEPTH / 4 + 3; n++) send_cmd_pair(8'hD4, 8'hE9);
        for (int n = 0; n < 20; n++) send_op(MODE_READ, 1'b0, 8'h00);
        send_op(MODE_WRITE, 1'b0, 8'hF6);
      end
    end

    while (replies_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && replies_due == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
src/ps2kc_pkg.sv
src/ps2kc_ram.sv
src/ps2kc_ctrl.sv
src/ps2kc_datapath.sv
src/ps2_keyboard_mouse_controller.sv
dv/ps2kc_checker.sv
dv/tb_ps2_keyboard_mouse_controller.sv
